### rtl/core/ett_pkg.sv
package ett_pkg;

   localparam int CHANNELS   = 3;
   localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int COUNT_W    = 16;
   localparam int TIME_W     = 16;
   localparam int ANGLE_W    = 48;
   localparam int SPEED_W    = 32;
   localparam int MOD_W      = 17;
   localparam int SCALE_W    = 32;
   localparam int DATA_W     = 32;
   localparam int ADDR_W     = 4;

   // Corrected count delta and its magnitude.
   localparam int DELTA_W    = 19;
   localparam int MAG_W      = 17;

   // Wrap threshold is modulus / 10, formed as a multiply by a reciprocal.
   localparam int THR_W        = 14;
   localparam int RECIP_W      = 20;
   localparam int RECIP_SHIFT  = 23;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 20'd838861;

   localparam int PROD_W     = 2 * SCALE_W;
   localparam int STEP_W     = MAG_W + SCALE_W - 16 + 1;
   localparam logic [SCALE_W-1:0] MS_PER_S = 32'd1000;
   localparam int NUM_W      = 61;
   localparam int DIVIDEND_W = NUM_W - 16;

   localparam logic [MOD_W-1:0]   WRAP_MODULUS_RESET   = 17'd65536;
   localparam logic [SCALE_W-1:0] POSITION_SCALE_RESET = 32'd674310;
   localparam logic [SCALE_W-1:0] VELOCITY_SCALE_RESET = 32'd67431;
   localparam logic [THR_W-1:0]   THRESHOLD_RESET      = 14'd6553;

   localparam logic [SPEED_W-1:0] SPEED_POS_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic [SPEED_W-1:0] SPEED_NEG_MAG = {1'b1, {(SPEED_W-1){1'b0}}};

   typedef enum logic [1:0] {
      REG_WRAP_MODULUS   = 2'd0,
      REG_POSITION_SCALE = 2'd1,
      REG_VELOCITY_SCALE = 2'd2
   } reg_index_type;

endpackage

### rtl/core/ett_if.sv
interface ett_req_if;
   logic                            valid;
   logic                            ready;
   logic [ett_pkg::COUNT_W-1:0]     count_a;
   logic [ett_pkg::COUNT_W-1:0]     count_b;
   logic [ett_pkg::COUNT_W-1:0]     count_c;
   logic [ett_pkg::TIME_W-1:0]      time_ms;

   modport source (output valid, count_a, count_b, count_c, time_ms, input ready);
   modport sink (input valid, count_a, count_b, count_c, time_ms, output ready);
endinterface

interface ett_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [ett_pkg::ANGLE_W-1:0] angle_a;
   logic signed [ett_pkg::ANGLE_W-1:0] angle_b;
   logic signed [ett_pkg::ANGLE_W-1:0] angle_c;
   logic signed [ett_pkg::SPEED_W-1:0] speed_a;
   logic signed [ett_pkg::SPEED_W-1:0] speed_b;
   logic signed [ett_pkg::SPEED_W-1:0] speed_c;
   logic                               speed_valid;

   modport source (output valid, angle_a, angle_b, angle_c, speed_a, speed_b, speed_c,
                   speed_valid, input ready);
   modport sink (input valid, angle_a, angle_b, angle_c, speed_a, speed_b, speed_c,
                 speed_valid, output ready);
endinterface

### rtl/core/ett_divider.sv
module ett_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [ett_pkg::DIVIDEND_W-1:0]     dividend,
   input  logic [ett_pkg::TIME_W-1:0]         divisor,
   output logic                               done,
   output logic [ett_pkg::DIVIDEND_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(ett_pkg::DIVIDEND_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ett_pkg::DIVIDEND_W - 1);

   logic                              busy_ff;
   logic                              done_ff;
   logic [CNT_W-1:0]                  count_ff;
   logic [ett_pkg::DIVIDEND_W-1:0]    work_ff;
   logic [ett_pkg::TIME_W-1:0]        rem_ff;
   logic [ett_pkg::TIME_W-1:0]        div_ff;
   logic [ett_pkg::TIME_W:0]          trial_in;
   logic [ett_pkg::TIME_W:0]          diff_in;
   logic                              fits_in;

   assign trial_in = {rem_ff, work_ff[ett_pkg::DIVIDEND_W-1]};
   assign diff_in  = trial_in - {1'b0, div_ff};
   assign fits_in  = trial_in >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
            work_ff  <= dividend;
            rem_ff   <= '0;
            div_ff   <= divisor;
         end else if (busy_ff) begin
            work_ff  <= {work_ff[ett_pkg::DIVIDEND_W-2:0], fits_in};
            rem_ff   <= fits_in ? diff_in[ett_pkg::TIME_W-1:0]
                                : trial_in[ett_pkg::TIME_W-1:0];
            count_ff <= count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = work_ff;

endmodule

### rtl/core/encoder_odometry_tracker.sv
// Channels are processed in turn with one shared 32x32 multiplier and a 45-step restoring
// divider, which is run once per channel and skipped when the time delta is zero.
// The input is accepted only while the sequencer is idle; a finished result waits in
// the output register. Synchronous active-high reset restores register defaults, clears
// angles, counts and timestamp, and marks the next packet as the first sample.
module encoder_odometry_tracker (
   input  logic                          clock,
   input  logic                          reset,
   ett_req_if.sink                       req_chan,
   ett_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ett_pkg::ADDR_W-1:0]    paddr,
   input  logic [ett_pkg::DATA_W-1:0]    pwdata,
   output logic [ett_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   typedef enum logic [2:0] {
      IDLE,
      DELTA,
      MUL_POS,
      ANGLE,
      MUL_VEL,
      DIV_LOAD,
      DIV_WAIT,
      FINISH
   } state_type;

   localparam int CHANNELS = ett_pkg::CHANNELS;
   localparam logic [ett_pkg::CH_W-1:0] LAST_CH = ett_pkg::CH_W'(CHANNELS - 1);

   state_type                            state_ff;
   logic [ett_pkg::CH_W-1:0]             ch_ff;

   logic [ett_pkg::MOD_W-1:0]            wrap_modulus_ff;
   logic [ett_pkg::SCALE_W-1:0]          position_scale_ff;
   logic [ett_pkg::SCALE_W-1:0]          velocity_scale_ff;
   logic [ett_pkg::THR_W-1:0]            threshold_ff;

   logic [ett_pkg::COUNT_W-1:0]          prev_count_ff [CHANNELS];
   logic [ett_pkg::COUNT_W-1:0]          count_ff [CHANNELS];
   logic [ett_pkg::TIME_W-1:0]           prev_time_ff;
   logic [ett_pkg::TIME_W-1:0]           dt_ff;
   logic                                 first_ff;
   logic [ett_pkg::ANGLE_W-1:0]          angle_ff [CHANNELS];
   logic [ett_pkg::SPEED_W-1:0]          speed_ff [CHANNELS];

   logic                                 neg_ff;
   logic [ett_pkg::MAG_W-1:0]            mag_ff;
   logic [ett_pkg::PROD_W-1:0]           prod_ff;

   logic                                 rsp_valid_ff;
   logic [ett_pkg::ANGLE_W-1:0]          rsp_angle_ff [CHANNELS];
   logic [ett_pkg::SPEED_W-1:0]          rsp_speed_ff [CHANNELS];
   logic                                 rsp_speed_valid_ff;

   logic [ett_pkg::COUNT_W-1:0]          cur_in;
   logic [ett_pkg::COUNT_W-1:0]          prev_in;
   logic signed [ett_pkg::DELTA_W-1:0]   d0_in;
   logic signed [ett_pkg::DELTA_W-1:0]   d1_in;
   logic signed [ett_pkg::DELTA_W-1:0]   d2_in;
   logic signed [ett_pkg::DELTA_W-1:0]   mod_in;
   logic signed [ett_pkg::DELTA_W-1:0]   thr_in;
   logic signed [ett_pkg::DELTA_W-1:0]   delta_in;
   logic [ett_pkg::DELTA_W-1:0]          abs_in;
   logic [ett_pkg::MOD_W+ett_pkg::RECIP_W-1:0] thr_prod_in;

   logic [ett_pkg::SCALE_W-1:0]          mult_a_in;
   logic [ett_pkg::SCALE_W-1:0]          mult_b_in;
   logic [ett_pkg::PROD_W-1:0]           product_in;

   logic [ett_pkg::MAG_W+ett_pkg::SCALE_W:0] step_sum_in;
   logic [ett_pkg::STEP_W-1:0]           step_in;
   logic [ett_pkg::ANGLE_W-1:0]          angle_in;

   logic [ett_pkg::NUM_W-1:0]            num_in;
   logic                                 div_start;
   logic                                 div_done;
   logic [ett_pkg::DIVIDEND_W-1:0]       div_quotient;
   logic [ett_pkg::SPEED_W-1:0]          speed_mag_in;
   logic [ett_pkg::SPEED_W-1:0]          speed_in;
   logic                                 csr_write;

   assign csr_write   = psel && penable && pwrite;
   assign thr_prod_in = {{ett_pkg::RECIP_W{1'b0}}, pwdata[ett_pkg::MOD_W-1:0]}
                        * {{ett_pkg::MOD_W{1'b0}}, ett_pkg::RECIP_TEN};

   // Per-channel count delta with counter wrap correction.
   always_comb begin
      cur_in   = count_ff[ch_ff];
      prev_in  = prev_count_ff[ch_ff];
      d0_in    = $signed({{(ett_pkg::DELTA_W-ett_pkg::COUNT_W){1'b0}}, cur_in})
               - $signed({{(ett_pkg::DELTA_W-ett_pkg::COUNT_W){1'b0}}, prev_in});
      mod_in   = $signed({{(ett_pkg::DELTA_W-ett_pkg::MOD_W){1'b0}}, wrap_modulus_ff});
      thr_in   = $signed({{(ett_pkg::DELTA_W-ett_pkg::THR_W){1'b0}}, threshold_ff});
      d1_in    = (d0_in > thr_in) ? d0_in - mod_in : d0_in;
      d2_in    = (d1_in < -thr_in) ? d1_in + mod_in : d1_in;
      delta_in = first_ff ? '0 : d2_in;
      abs_in   = delta_in[ett_pkg::DELTA_W-1] ? -delta_in : delta_in;
   end

   always_comb begin
      unique case (state_ff)
         MUL_POS: begin
            mult_a_in = {{(ett_pkg::SCALE_W-ett_pkg::MAG_W){1'b0}}, mag_ff};
            mult_b_in = position_scale_ff;
         end
         ANGLE: begin
            mult_a_in = {{(ett_pkg::SCALE_W-ett_pkg::MAG_W){1'b0}}, mag_ff};
            mult_b_in = ett_pkg::MS_PER_S;
         end
         MUL_VEL: begin
            mult_a_in = prod_ff[ett_pkg::SCALE_W-1:0];
            mult_b_in = velocity_scale_ff;
         end
         default: begin
            mult_a_in = '0;
            mult_b_in = '0;
         end
      endcase
   end

   assign product_in = {{ett_pkg::SCALE_W{1'b0}}, mult_a_in}
                     * {{ett_pkg::SCALE_W{1'b0}}, mult_b_in};

   // Angle increment: Q.32 product rounded half up to Q.16 on the magnitude.
   assign step_sum_in = {1'b0, prod_ff[ett_pkg::MAG_W+ett_pkg::SCALE_W-1:0]}
                      + (ett_pkg::MAG_W+ett_pkg::SCALE_W+1)'(32768);
   assign step_in     = step_sum_in[ett_pkg::MAG_W+ett_pkg::SCALE_W:16];
   assign angle_in    = neg_ff
      ? angle_ff[ch_ff] - {{(ett_pkg::ANGLE_W-ett_pkg::STEP_W){1'b0}}, step_in}
      : angle_ff[ch_ff] + {{(ett_pkg::ANGLE_W-ett_pkg::STEP_W){1'b0}}, step_in};

   // Rounded speed quotient: (num + dt * 2^15) / (dt * 2^16) taken as a division by dt.
   assign num_in    = {1'b0, prod_ff[ett_pkg::NUM_W-2:0]}
                    + {{(ett_pkg::NUM_W-ett_pkg::TIME_W-15){1'b0}}, dt_ff, 15'b0};
   assign div_start = (state_ff == DIV_LOAD) && (dt_ff != '0);

   ett_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_in[ett_pkg::NUM_W-1:16]),
      .divisor  (dt_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      if (neg_ff) begin
         speed_mag_in = (div_quotient > {{(ett_pkg::DIVIDEND_W-ett_pkg::SPEED_W){1'b0}},
                                         ett_pkg::SPEED_NEG_MAG})
                        ? ett_pkg::SPEED_NEG_MAG : div_quotient[ett_pkg::SPEED_W-1:0];
         speed_in     = -speed_mag_in;
      end else begin
         speed_mag_in = (div_quotient > {{(ett_pkg::DIVIDEND_W-ett_pkg::SPEED_W){1'b0}},
                                         ett_pkg::SPEED_POS_MAX})
                        ? ett_pkg::SPEED_POS_MAX : div_quotient[ett_pkg::SPEED_W-1:0];
         speed_in     = speed_mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= IDLE;
         ch_ff             <= '0;
         wrap_modulus_ff   <= ett_pkg::WRAP_MODULUS_RESET;
         position_scale_ff <= ett_pkg::POSITION_SCALE_RESET;
         velocity_scale_ff <= ett_pkg::VELOCITY_SCALE_RESET;
         threshold_ff      <= ett_pkg::THRESHOLD_RESET;
         prev_time_ff      <= '0;
         first_ff          <= 1'b1;
         rsp_valid_ff      <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            prev_count_ff[i] <= '0;
            angle_ff[i]      <= '0;
         end
      end else begin
         if (csr_write) begin
            case (paddr[ett_pkg::ADDR_W-1:2])
               ett_pkg::REG_WRAP_MODULUS: begin
                  wrap_modulus_ff <= pwdata[ett_pkg::MOD_W-1:0];
                  threshold_ff    <= thr_prod_in[ett_pkg::RECIP_SHIFT +: ett_pkg::THR_W];
               end
               ett_pkg::REG_POSITION_SCALE: begin
                  position_scale_ff <= pwdata[ett_pkg::SCALE_W-1:0];
               end
               ett_pkg::REG_VELOCITY_SCALE: begin
                  velocity_scale_ff <= pwdata[ett_pkg::SCALE_W-1:0];
               end
               default: begin
               end
            endcase
         end

         if (rsp_valid_ff && rsp_chan.ready && (state_ff != FINISH)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            IDLE: begin
               if (req_chan.valid) begin
                  count_ff[0]  <= req_chan.count_a;
                  count_ff[1]  <= req_chan.count_b;
                  count_ff[2]  <= req_chan.count_c;
                  dt_ff        <= req_chan.time_ms - prev_time_ff;
                  prev_time_ff <= req_chan.time_ms;
                  ch_ff        <= '0;
                  state_ff     <= DELTA;
               end
            end
            DELTA: begin
               neg_ff                <= delta_in[ett_pkg::DELTA_W-1];
               mag_ff                <= abs_in[ett_pkg::MAG_W-1:0];
               prev_count_ff[ch_ff]  <= count_ff[ch_ff];
               state_ff              <= MUL_POS;
            end
            MUL_POS: begin
               prod_ff  <= product_in;
               state_ff <= ANGLE;
            end
            ANGLE: begin
               angle_ff[ch_ff] <= angle_in;
               prod_ff         <= product_in;
               state_ff        <= MUL_VEL;
            end
            MUL_VEL: begin
               prod_ff  <= product_in;
               state_ff <= DIV_LOAD;
            end
            DIV_LOAD: begin
               if (dt_ff == '0) begin
                  speed_ff[ch_ff] <= '0;
                  if (ch_ff == LAST_CH) begin
                     state_ff <= FINISH;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= DELTA;
                  end
               end else begin
                  state_ff <= DIV_WAIT;
               end
            end
            DIV_WAIT: begin
               if (div_done) begin
                  speed_ff[ch_ff] <= speed_in;
                  if (ch_ff == LAST_CH) begin
                     state_ff <= FINISH;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     state_ff <= DELTA;
                  end
               end
            end
            FINISH: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  for (int i = 0; i < CHANNELS; i++) begin
                     rsp_angle_ff[i] <= angle_ff[i];
                     rsp_speed_ff[i] <= speed_ff[i];
                  end
                  rsp_speed_valid_ff <= dt_ff != '0;
                  rsp_valid_ff       <= 1'b1;
                  first_ff           <= 1'b0;
                  state_ff           <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[ett_pkg::ADDR_W-1:2])
         ett_pkg::REG_WRAP_MODULUS:
            prdata = {{(ett_pkg::DATA_W-ett_pkg::MOD_W){1'b0}}, wrap_modulus_ff};
         ett_pkg::REG_POSITION_SCALE:
            prdata = position_scale_ff;
         ett_pkg::REG_VELOCITY_SCALE:
            prdata = velocity_scale_ff;
         default:
            prdata = '0;
      endcase
   end

   assign pready = 1'b1;

   assign req_chan.ready       = (state_ff == IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.angle_a     = $signed(rsp_angle_ff[0]);
   assign rsp_chan.angle_b     = $signed(rsp_angle_ff[1]);
   assign rsp_chan.angle_c     = $signed(rsp_angle_ff[2]);
   assign rsp_chan.speed_a     = $signed(rsp_speed_ff[0]);
   assign rsp_chan.speed_b     = $signed(rsp_speed_ff[1]);
   assign rsp_chan.speed_c     = $signed(rsp_speed_ff[2]);
   assign rsp_chan.speed_valid = rsp_speed_valid_ff;

endmodule

### rtl/core/ett_checker.sv
module ett_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [ett_pkg::ANGLE_W-1:0] angle_a,
   input logic signed [ett_pkg::SPEED_W-1:0] speed_a,
   input logic signed [ett_pkg::SPEED_W-1:0] speed_b,
   input logic signed [ett_pkg::SPEED_W-1:0] speed_c,
   input logic                               speed_valid
);

   // A result that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before its transfer");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(angle_a) && $stable(speed_a))
      else $error("result payload changed while stalled");

   // The block works on one packet at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted again while a packet is in work");

   // A zero time delta forces every speed to zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !speed_valid |-> speed_a == '0 && speed_b == '0 && speed_c == '0)
      else $error("nonzero speed reported with an invalid time delta");

endmodule

bind encoder_odometry_tracker ett_checker u_ett_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .angle_a     (rsp_chan.angle_a),
   .speed_a     (rsp_chan.speed_a),
   .speed_b     (rsp_chan.speed_b),
   .speed_c     (rsp_chan.speed_c),
   .speed_valid (rsp_chan.speed_valid)
);

### verif/tb_encoder_odometry_tracker.sv
`timescale 1ns / 1ps

typedef struct packed {
   logic [ett_pkg::CHANNELS-1:0][ett_pkg::COUNT_W-1:0] count;
   logic [ett_pkg::TIME_W-1:0]                         time_ms;
} encoder_sample_type;

typedef struct packed {
   logic [ett_pkg::CHANNELS-1:0][ett_pkg::ANGLE_W-1:0] angle;
   logic [ett_pkg::CHANNELS-1:0][ett_pkg::SPEED_W-1:0] speed;
   logic                                               speed_valid;
} odometry_type;

class odometry_checker;
   bit [63:0]                  modulus;
   bit [63:0]                  pos_scale;
   bit [63:0]                  vel_scale;
   bit [ett_pkg::COUNT_W-1:0]  last_count [ett_pkg::CHANNELS];
   bit [ett_pkg::TIME_W-1:0]   last_time;
   bit                         first_packet;
   bit [ett_pkg::ANGLE_W-1:0]  angle_acc [ett_pkg::CHANNELS];
   odometry_type               expected_odometry [$];
   int                         mismatches;
   int                         checked;
   int                         noted;
   int                         zero_dt;
   int                         saturated;

   function new();
      int i;
      modulus = 64'(ett_pkg::WRAP_MODULUS_RESET);
      pos_scale = 64'(ett_pkg::POSITION_SCALE_RESET);
      vel_scale = 64'(ett_pkg::VELOCITY_SCALE_RESET);
      for (i = 0; i < ett_pkg::CHANNELS; i++) begin
         last_count[i] = '0;
         angle_acc[i] = '0;
      end
      last_time = '0;
      first_packet = 1'b1;
   endfunction

   function void set_register(logic [1:0] index, logic [ett_pkg::DATA_W-1:0] value);
      case (index)
         ett_pkg::REG_WRAP_MODULUS: begin
            modulus = 64'(value[ett_pkg::MOD_W-1:0]);
         end
         ett_pkg::REG_POSITION_SCALE: begin
            pos_scale = 64'(value);
         end
         ett_pkg::REG_VELOCITY_SCALE: begin
            vel_scale = 64'(value);
         end
         default: begin
         end
      endcase
   endfunction

   function logic [ett_pkg::DATA_W-1:0] register_value(logic [1:0] index);
      case (index)
         ett_pkg::REG_WRAP_MODULUS:   return modulus[ett_pkg::DATA_W-1:0];
         ett_pkg::REG_POSITION_SCALE: return pos_scale[ett_pkg::DATA_W-1:0];
         ett_pkg::REG_VELOCITY_SCALE: return vel_scale[ett_pkg::DATA_W-1:0];
         default:                     return '0;
      endcase
   endfunction

   function void report(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("MISMATCH at %0t: %s", $realtime, msg);
      end
   endfunction

   function longint corrected_delta(bit [ett_pkg::COUNT_W-1:0] now_count,
                                    bit [ett_pkg::COUNT_W-1:0] old_count);
      longint d;
      longint thr;
      longint m;
      m = longint'(modulus);
      thr = m / 10;
      d = longint'({48'd0, now_count}) - longint'({48'd0, old_count});
      if (d > thr) d -= m;
      if (d < -thr) d += m;
      return d;
   endfunction

   function bit [ett_pkg::ANGLE_W-1:0] angle_increment(longint d);
      bit [63:0] mag;
      bit [63:0] r;
      mag = (d < 0) ? -d : d;
      r = (mag * pos_scale + 64'd32768) >> 16;
      if (d < 0) r = 64'd0 - r;
      return r[ett_pkg::ANGLE_W-1:0];
   endfunction

   function bit [ett_pkg::SPEED_W-1:0] speed_estimate(longint d, bit [63:0] dt);
      bit [63:0] mag;
      bit [63:0] num;
      bit [63:0] den;
      bit [63:0] q;
      mag = (d < 0) ? -d : d;
      num = mag * vel_scale * 64'd1000;
      den = dt << 16;
      q = (num + den / 2) / den;
      if (d < 0) begin
         if (q > 64'h8000_0000) begin
            q = 64'h8000_0000;
            saturated++;
         end
         q = 64'd0 - q;
      end else if (q > 64'h7FFF_FFFF) begin
         q = 64'h7FFF_FFFF;
         saturated++;
      end
      return q[ett_pkg::SPEED_W-1:0];
   endfunction

   function void note_sample(encoder_sample_type s);
      odometry_type               e;
      bit [ett_pkg::TIME_W-1:0]   dt;
      longint                     d;
      int                         i;
      dt = s.time_ms - last_time;
      e.speed_valid = (dt != 0);
      for (i = 0; i < ett_pkg::CHANNELS; i++) begin
         d = first_packet ? 0 : corrected_delta(s.count[i], last_count[i]);
         last_count[i] = s.count[i];
         angle_acc[i] = angle_acc[i] + angle_increment(d);
         e.angle[i] = angle_acc[i];
         e.speed[i] = e.speed_valid ? speed_estimate(d, {48'd0, dt}) : '0;
      end
      last_time = s.time_ms;
      first_packet = 1'b0;
      if (!e.speed_valid) zero_dt++;
      noted++;
      expected_odometry.push_back(e);
   endfunction

   function void compare_field(string name, logic [63:0] e, logic [63:0] g);
      if (g !== e) begin
         report($sformatf("result %0d %s: expected 0x%0h, got 0x%0h", checked, name, e, g));
      end
   endfunction

   function void check_result(odometry_type got);
      odometry_type e;
      int           i;
      if (expected_odometry.size() == 0) begin
         report("result transfer with no sample outstanding");
         return;
      end
      e = expected_odometry.pop_front();
      checked++;
      for (i = 0; i < ett_pkg::CHANNELS; i++) begin
         compare_field($sformatf("angle_%c", 8'd97 + i), {16'd0, e.angle[i]},
                       {16'd0, got.angle[i]});
         compare_field($sformatf("speed_%c", 8'd97 + i), {32'd0, e.speed[i]},
                       {32'd0, got.speed[i]});
      end
      compare_field("speed_valid", {63'd0, e.speed_valid}, {63'd0, got.speed_valid});
   endfunction

   function int pending();
      return expected_odometry.size();
   endfunction

   function int failures();
      return mismatches + expected_odometry.size();
   endfunction
endclass

module tb_encoder_odometry_tracker;
   localparam int         CYCLE_LIMIT         = 1_000_000;
   localparam int         RESET_CYCLES        = 6;
   localparam int         DRAIN_CYCLES        = 200;
   localparam int         BACKPRESSURE_CYCLES = 3000;
   localparam logic [1:0] REG_UNMAPPED        = 2'd3;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [ett_pkg::ADDR_W-1:0]  paddr;
   logic [ett_pkg::DATA_W-1:0]  pwdata;
   logic [ett_pkg::DATA_W-1:0]  prdata;
   logic                        pready;

   odometry_checker             odo;
   bit                          idle_on = 1'b1;
   bit                          hold_request = 1'b0;
   int unsigned                 cycle_count = 0;
   int                          settings_count = 0;
   bit [ett_pkg::COUNT_W-1:0]   sent_count [ett_pkg::CHANNELS];
   bit [ett_pkg::TIME_W-1:0]    sent_time;

   ett_req_if req_chan ();
   ett_rsp_if rsp_chan ();

   encoder_odometry_tracker dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, odo.pending());
         $display("encoder_odometry_tracker test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      encoder_sample_type s;
      odometry_type       r;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            s.count[0] = req_chan.count_a;
            s.count[1] = req_chan.count_b;
            s.count[2] = req_chan.count_c;
            s.time_ms = req_chan.time_ms;
            odo.note_sample(s);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            r.angle[0] = rsp_chan.angle_a;
            r.angle[1] = rsp_chan.angle_b;
            r.angle[2] = rsp_chan.angle_c;
            r.speed[0] = rsp_chan.speed_a;
            r.speed[1] = rsp_chan.speed_b;
            r.speed[2] = rsp_chan.speed_c;
            r.speed_valid = rsp_chan.speed_valid;
            odo.check_result(r);
         end
      end
   end

   // The receiver runs on its own so that a long hold-off can overlap ongoing transfers.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready = 1'b0;
            repeat (BACKPRESSURE_CYCLES - 1) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
         end
      end
   end

   task automatic send_sample(bit [ett_pkg::COUNT_W-1:0] ca, bit [ett_pkg::COUNT_W-1:0] cb,
                              bit [ett_pkg::COUNT_W-1:0] cc, bit [ett_pkg::TIME_W-1:0] tm);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.count_a = ca;
      req_chan.count_b = cb;
      req_chan.count_c = cc;
      req_chan.time_ms = tm;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      sent_count[0] = ca;
      sent_count[1] = cb;
      sent_count[2] = cc;
      sent_time = tm;
   endtask

   task automatic wait_for_results();
      req_chan.valid = 1'b0;
      while (odo.pending() != 0) @(negedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [ett_pkg::DATA_W-1:0] value);
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = {index, 2'b00};
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      odo.set_register(index, value);
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
   endtask

   task automatic check_register(logic [1:0] index);
      logic [ett_pkg::DATA_W-1:0] data;
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = {index, 2'b00};
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      data = prdata;
      if (data !== odo.register_value(index)) begin
         odo.report($sformatf("register %0d read: expected 0x%0h, got 0x%0h",
                              index, odo.register_value(index), data));
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic verify_registers();
      check_register(ett_pkg::REG_WRAP_MODULUS);
      check_register(ett_pkg::REG_POSITION_SCALE);
      check_register(ett_pkg::REG_VELOCITY_SCALE);
   endtask

   task automatic apply_settings(logic [ett_pkg::DATA_W-1:0] modulus,
                                 logic [ett_pkg::DATA_W-1:0] pos_scale,
                                 logic [ett_pkg::DATA_W-1:0] vel_scale);
      write_register(ett_pkg::REG_WRAP_MODULUS, modulus);
      write_register(ett_pkg::REG_POSITION_SCALE, pos_scale);
      write_register(ett_pkg::REG_VELOCITY_SCALE, vel_scale);
      write_register(REG_UNMAPPED, $urandom);
      verify_registers();
      settings_count++;
   endtask

   function automatic bit [ett_pkg::COUNT_W-1:0] next_count(bit [ett_pkg::COUNT_W-1:0] prev,
                                                            int thr);
      int delta;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            delta = int'($urandom_range(0, 400)) - 200;
         end
         5, 6: begin
            delta = thr - 2 + int'($urandom_range(0, 4));
            if ($urandom_range(0, 1) == 1) delta = -delta;
         end
         7: begin
            delta = 65536 - int'($urandom_range(1, 300));
            if ($urandom_range(0, 1) == 1) delta = -delta;
         end
         default: begin
            return ett_pkg::COUNT_W'($urandom_range(0, 65535));
         end
      endcase
      return prev + delta[ett_pkg::COUNT_W-1:0];
   endfunction

   function automatic bit [ett_pkg::TIME_W-1:0] next_time(bit [ett_pkg::TIME_W-1:0] prev);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return ett_pkg::TIME_W'(prev + $urandom_range(1, 20));
         6:                return prev;
         7:                return ett_pkg::TIME_W'(prev + $urandom_range(1, 1000));
         8:                return ett_pkg::TIME_W'($urandom_range(0, 65535));
         default:          return prev + 1'b1;
      endcase
   endfunction

   task automatic random_samples(int n);
      int k;
      int thr;
      for (k = 0; k < n; k++) begin
         thr = int'(odo.modulus / 10);
         send_sample(next_count(sent_count[0], thr), next_count(sent_count[1], thr),
                     next_count(sent_count[2], thr), next_time(sent_time));
      end
      wait_for_results();
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.count_a = '0;
      req_chan.count_b = '0;
      req_chan.count_c = '0;
      req_chan.time_ms = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      sent_count[0] = '0;
      sent_count[1] = '0;
      sent_count[2] = '0;
      sent_time = '0;
      odo = new();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      verify_registers();
      settings_count++;
      send_sample(16'd12345, 16'd65535, 16'd0, 16'd0);
      send_sample(16'd18898, 16'd58982, 16'd1, 16'd1);
      send_sample(16'd25452, 16'd52428, 16'd0, 16'd1);
      send_sample(16'd25452, 16'd65535, 16'd65535, 16'd3);
      send_sample(16'd2, 16'd0, 16'd4, 16'd65535);
      send_sample(16'd2, 16'd0, 16'd4, 16'd2);
      send_sample(16'd65535, 16'd65535, 16'd65535, 16'd1);
      send_sample(16'd0, 16'd0, 16'd0, 16'd1);
      wait_for_results();

      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_sample(16'd13000, 16'd52536, 16'd100, 16'd2);
      send_sample(16'd13000, 16'd52536, 16'd100, 16'd2);
      send_sample(16'd0, 16'd13000, 16'd65535, 16'd5);
      send_sample(16'd65535, 16'd0, 16'd32768, 16'd6);
      wait_for_results();

      apply_settings(32'd0, 32'd0, 32'd0);
      send_sample(16'd100, 16'd65000, 16'd7, 16'd9);
      send_sample(16'd50, 16'd65535, 16'd7, 16'd10);
      wait_for_results();

      apply_settings(32'd1, 32'd1, 32'd1);
      send_sample(16'd1, 16'd2, 16'd3, 16'd11);
      send_sample(16'd0, 16'd0, 16'd0, 16'd11);
      send_sample(16'd65535, 16'd1, 16'd40000, 16'd12);
      wait_for_results();

      apply_settings(32'(ett_pkg::WRAP_MODULUS_RESET), ett_pkg::POSITION_SCALE_RESET,
                     ett_pkg::VELOCITY_SCALE_RESET);
      hold_request = 1'b1;
      random_samples(200);

      apply_settings($urandom_range(1, 65536), $urandom, $urandom);
      random_samples(150);

      idle_on = 1'b0;
      apply_settings(32'(ett_pkg::WRAP_MODULUS_RESET), $urandom, $urandom);
      random_samples(150);

      idle_on = 1'b1;
      apply_settings($urandom_range(0, 131071), $urandom, $urandom);
      hold_request = 1'b1;
      random_samples(150);

      idle_on = 1'b0;
      apply_settings(32'(ett_pkg::WRAP_MODULUS_RESET), 32'hFFFF_FFFF, $urandom);
      random_samples(150);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results from %0d samples over %0d register settings.",
               odo.checked, odo.noted, settings_count);
      $display("Of these, %0d had a zero time delta and %0d speeds hit saturation.",
               odo.zero_dt, odo.saturated);
      if (odo.pending() != 0) begin
         $display("%0d expected results never arrived", odo.pending());
      end
      if (odo.failures() == 0) begin
         $display("encoder_odometry_tracker test passed");
      end else begin
         $display("encoder_odometry_tracker test failed");
      end
      $finish;
   end
endmodule

### encoder_odometry_tracker.f
rtl/core/ett_pkg.sv
rtl/core/ett_if.sv
rtl/core/ett_divider.sv
rtl/core/encoder_odometry_tracker.sv
rtl/core/ett_checker.sv
verif/tb_encoder_odometry_tracker.sv
